FILE: hdl/sorted_list_set_merge_unit_defines.svh
// Assertion macros shared by the checker of the set merge unit.
`ifndef SORTED_LIST_SET_MERGE_UNIT_DEFINES_SVH
`define SORTED_LIST_SET_MERGE_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SLSM_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("set merge unit: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define SLSM_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("set merge unit: next-cycle check failed");

`endif

FILE: hdl/slsm_pkg.sv
package slsm_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned MODE_W   = 2;

  // Item actions.
  localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RUN    = 2'd2;

  // Merge modes. Bit 1 selects difference; otherwise bit 0 selects union.
  localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNION     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_res;
    logic               last;
    logic               empty_res;
    logic               overflow;
  } out_item_t;

  // Command from the load side to the merge walker.
  typedef struct packed {
    logic              go;
    logic [MODE_W-1:0] mode;
    logic              overflow;
  } run_cmd_t;

  // Status from the merge walker.
  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

endpackage

FILE: hdl/slsm_list_mem.sv
module slsm_list_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/slsm_merge_ctrl.sv
module slsm_merge_ctrl import slsm_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned ID_WIDTH   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  run_cmd_t                             cmd_i,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]      cnt_a_i,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]      cnt_b_i,
  input  logic [ID_WIDTH-1:0]                  rd_a_i,
  input  logic [ID_WIDTH-1:0]                  rd_b_i,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] raddr_a_o,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] raddr_b_o,
  output walk_stat_t                           stat_o,
  output logic                                 result_valid_o,
  output out_item_t                            result_o
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic {ST_IDLE, ST_WALK} state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       i_q, i_d, j_q, j_d;
  logic                pend_valid_q, pend_valid_d;
  logic [ID_WIDTH-1:0] pend_val_q, pend_val_d;
  logic                res_valid_q, res_valid_d;
  out_item_t           res_q, res_d;

  logic                have_a, have_b, is_diff, is_uni, is_inter;
  logic                emit, adv_i, adv_j, fin;
  logic [ID_WIDTH-1:0] emit_val;

  assign is_diff  = cmd_i.mode[1];
  assign is_uni   = !cmd_i.mode[1] && cmd_i.mode[0];
  assign is_inter = !is_diff && !is_uni;
  assign have_a   = i_q < cnt_a_i;
  assign have_b   = j_q < cnt_b_i;

  // One step of the two-pointer walk on the current heads of both lists.
  always_comb begin
    emit     = 1'b0;
    emit_val = rd_a_i;
    adv_i    = 1'b0;
    adv_j    = 1'b0;
    fin      = 1'b0;
    if (have_a && have_b) begin
      if (rd_a_i < rd_b_i) begin
        emit  = !is_inter;
        adv_i = 1'b1;
      end else if (rd_b_i < rd_a_i) begin
        emit     = is_uni;
        emit_val = rd_b_i;
        adv_j    = 1'b1;
      end else begin
        emit  = !is_diff;
        adv_i = 1'b1;
        adv_j = 1'b1;
      end
    end else if (have_a && !is_inter) begin
      emit  = 1'b1;
      adv_i = 1'b1;
    end else if (have_b && is_uni) begin
      emit     = 1'b1;
      emit_val = rd_b_i;
      adv_j    = 1'b1;
    end else begin
      fin = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    i_d          = '0;
    j_d          = '0;
    pend_valid_d = pend_valid_q;
    pend_val_d   = pend_val_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.go) begin
          state_d      = ST_WALK;
          pend_valid_d = 1'b0;
        end
      end
      ST_WALK: begin
        i_d = adv_i ? i_q + CW'(1) : i_q;
        j_d = adv_j ? j_q + CW'(1) : j_q;
        if (fin) begin
          // The held id becomes the final result, or the run had none at all.
          state_d         = ST_IDLE;
          i_d             = '0;
          j_d             = '0;
          pend_valid_d    = 1'b0;
          res_valid_d     = 1'b1;
          res_d.value_res = pend_valid_q ? VALUE_W'(pend_val_q) : '0;
          res_d.last      = 1'b1;
          res_d.empty_res = !pend_valid_q;
          res_d.overflow  = cmd_i.overflow;
        end else if (emit) begin
          pend_valid_d    = 1'b1;
          pend_val_d      = emit_val;
          res_valid_d     = pend_valid_q;
          res_d.value_res = VALUE_W'(pend_val_q);
          res_d.last      = 1'b0;
          res_d.empty_res = 1'b0;
          res_d.overflow  = cmd_i.overflow;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      pend_valid_q <= 1'b0;
      pend_val_q   <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_valid_q <= pend_valid_d;
      pend_val_q   <= pend_val_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  // Reads are issued from the next pointer, so the data matches the pointer
  // in the cycle after.
  assign raddr_a_o = (i_d < CW'(LIST_DEPTH)) ? i_d[AW-1:0] : '0;
  assign raddr_b_o = (j_d < CW'(LIST_DEPTH)) ? j_d[AW-1:0] : '0;

  assign stat_o.busy    = (state_q == ST_WALK);
  assign stat_o.done    = (state_q == ST_WALK) && fin;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: hdl/sorted_list_set_merge_unit.sv
// Sorted list set merge unit. Items are issued with start while busy is low.
// A load item (action 0 or 1) appends its id, masked to ID_WIDTH bits, to
// list A or list B; a load into a full list is dropped and sets the overflow
// flag. A run item (action 2) merges the two lists under the mode held in the
// configuration register: intersection, union with shared ids given once, or
// difference A minus B (mode 3 also means difference). The run keeps busy high
// through every step of the two-pointer walk and a closing step, since each
// list memory delivers one element per cycle through its single read port.
// Results come out one per cycle at most, each on result_o for exactly one
// cycle with result_valid_o high; the receiver cannot stall the unit and must
// take every result as it appears. The final result of a run has last set; a
// run with no ids gives a single result with empty_res set and a zero id.
// Every result of a run carries the overflow flag, and the run clears both
// lists and the flag. Item action 3 is accepted and ignored. The
// configuration register is written with cfg_we_i and should only change
// while the unit is idle.
module sorted_list_set_merge_unit import slsm_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned ID_WIDTH   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item_i,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  output logic              result_valid_o,
  output out_item_t         result_o
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [MODE_W-1:0]   mode_q;
  logic [CW-1:0]       cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                ovf_q, ovf_d;
  logic                accept, load_a, load_b, we_a, we_b;
  logic [ID_WIDTH-1:0] load_val, rd_a, rd_b;
  logic [AW-1:0]       raddr_a, raddr_b;
  run_cmd_t            cmd;
  walk_stat_t          stat;

  // An item is taken whenever start is seen while the walker is idle.
  assign accept   = start && !busy;
  assign load_a   = accept && (item_i.action == ACT_LOAD_A);
  assign load_b   = accept && (item_i.action == ACT_LOAD_B);
  assign load_val = item_i.value[ID_WIDTH-1:0];
  assign we_a     = load_a && (cnt_a_q < CW'(LIST_DEPTH));
  assign we_b     = load_b && (cnt_b_q < CW'(LIST_DEPTH));

  // Counts and the overflow flag stay valid through the walk and are cleared
  // on its closing cycle. No load can arrive then since busy is high.
  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ovf_d   = ovf_q;
    if (stat.done) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
    end else begin
      if (we_a) begin
        cnt_a_d = cnt_a_q + CW'(1);
      end
      if (we_b) begin
        cnt_b_d = cnt_b_q + CW'(1);
      end
      if ((load_a && !we_a) || (load_b && !we_b)) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_INTERSECT;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ovf_q   <= ovf_d;
    end
  end

  // List memories: writes come from loads while idle and reads from the walker,
  // whose read data is only used while busy.
  slsm_list_mem #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (ID_WIDTH),
    .AW    (AW)
  ) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (load_val),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  slsm_list_mem #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (ID_WIDTH),
    .AW    (AW)
  ) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (load_val),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  assign cmd.go       = accept && (item_i.action == ACT_RUN);
  assign cmd.mode     = mode_q;
  assign cmd.overflow = ovf_q;

  slsm_merge_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cnt_a_i        (cnt_a_q),
    .cnt_b_i        (cnt_b_q),
    .rd_a_i         (rd_a),
    .rd_b_i         (rd_b),
    .raddr_a_o      (raddr_a),
    .raddr_b_o      (raddr_b),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  assign busy = stat.busy;

endmodule

FILE: hdl/slsm_checker.sv
`include "sorted_list_set_merge_unit_defines.svh"

module slsm_port_checks import slsm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input in_item_t          item_i,
  input logic              result_valid_o,
  input out_item_t         result_o
);

  logic empty_seen;
  logic empty_ok;
  logic run_taken;
  logic mid_result;

  assign empty_seen = result_valid_o && result_o.empty_res;
  assign empty_ok   = result_o.last && (result_o.value_res == '0);
  assign run_taken  = start && !busy && (item_i.action == ACT_RUN);
  assign mid_result = result_valid_o && !result_o.last;

  // An empty answer is a single, final result with a zero id.
  `SLSM_ASSERT_SAME(a_empty_is_last, clk_i, rst_ni, empty_seen, empty_ok)

  // A run item starts the walk on the next cycle.
  `SLSM_ASSERT_NEXT(a_run_sets_busy, clk_i, rst_ni, run_taken, busy)

  // More results are due after a result that is not the last one.
  `SLSM_ASSERT_SAME(a_more_while_busy, clk_i, rst_ni, mid_result, busy)

  // Results only follow a cycle of walking.
  `SLSM_ASSERT_SAME(a_result_after_busy, clk_i, rst_ni, result_valid_o, $past(busy))

  // The end of a walk always shows the final result.
  `SLSM_ASSERT_SAME(a_end_gives_last, clk_i, rst_ni, $fell(busy), result_valid_o && result_o.last)

endmodule

bind sorted_list_set_merge_unit slsm_port_checks u_slsm_port_checks (.*);

FILE: bench/slsm_checker.sv
module slsm_checker import slsm_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned ID_WIDTH   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  in_item_t          item_i,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  input  logic              result_valid_i,
  input  out_item_t         result_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  localparam logic [VALUE_W-1:0] ID_MASK = {VALUE_W{1'b1}} >> (VALUE_W - ID_WIDTH);

  // Shadow copy of the two id lists, their fill levels and the merge mode.
  logic [VALUE_W-1:0] list_a [LIST_DEPTH];
  logic [VALUE_W-1:0] list_b [LIST_DEPTH];
  int unsigned        len_a;
  int unsigned        len_b;
  logic               dropped;
  logic [MODE_W-1:0]  mode;

  out_item_t          merged_q [$];
  out_item_t          want;
  int unsigned        fail_count;

  function automatic void append_id(ref logic [VALUE_W-1:0] ids [LIST_DEPTH],
                                    ref int unsigned len, input logic [VALUE_W-1:0] id);
    if (len < LIST_DEPTH) begin
      ids[len] = id & ID_MASK;
      len++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // Two-pointer walk over the stored order, then the merged ids are queued
  // as the results the run has to produce.
  task automatic merge_lists();
    logic [VALUE_W-1:0] ids [2*LIST_DEPTH];
    int unsigned        n;
    int unsigned        ia;
    int unsigned        ib;
    logic               is_diff;
    logic               is_union;
    logic               is_inter;
    out_item_t          r;
    n        = 0;
    ia       = 0;
    ib       = 0;
    is_diff  = mode[1];
    is_union = !mode[1] && mode[0];
    is_inter = !is_diff && !is_union;
    while (ia < len_a && ib < len_b) begin
      if (list_a[ia] < list_b[ib]) begin
        if (!is_inter) begin
          ids[n] = list_a[ia];
          n++;
        end
        ia++;
      end else if (list_b[ib] < list_a[ia]) begin
        if (is_union) begin
          ids[n] = list_b[ib];
          n++;
        end
        ib++;
      end else begin
        if (!is_diff) begin
          ids[n] = list_a[ia];
          n++;
        end
        ia++;
        ib++;
      end
    end
    if (!is_inter) begin
      while (ia < len_a) begin
        ids[n] = list_a[ia];
        n++;
        ia++;
      end
    end
    if (is_union) begin
      while (ib < len_b) begin
        ids[n] = list_b[ib];
        n++;
        ib++;
      end
    end
    r.overflow = dropped;
    if (n == 0) begin
      r.value_res = '0;
      r.last      = 1'b1;
      r.empty_res = 1'b1;
      merged_q = {merged_q, r};
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        r.value_res = ids[k];
        r.last      = (k + 1 == n);
        r.empty_res = 1'b0;
        merged_q = {merged_q, r};
      end
    end
    len_a   = 0;
    len_b   = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a = 0;
      len_b = 0;
      dropped = 1'b0;
      mode = MODE_INTERSECT;
      merged_q.delete();
      fail_count = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        mode = cfg_wdata_i;
      end
      if (result_valid_i) begin
        if (merged_q.size() == 0) begin
          $error("unexpected result: value_res %0h last %0b empty_res %0b overflow %0b",
                 result_i.value_res, result_i.last, result_i.empty_res, result_i.overflow);
          fail_count++;
        end else begin
          want = merged_q.pop_front();
          if (result_i.value_res !== want.value_res) begin
            $error("value_res mismatch: expected %0h, actual %0h",
                   want.value_res, result_i.value_res);
            fail_count++;
          end
          if (result_i.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, result_i.last);
            fail_count++;
          end
          if (result_i.empty_res !== want.empty_res) begin
            $error("empty_res mismatch: expected %0b, actual %0b",
                   want.empty_res, result_i.empty_res);
            fail_count++;
          end
          if (result_i.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   want.overflow, result_i.overflow);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        case (item_i.action)
          ACT_LOAD_A: append_id(list_a, len_a, item_i.value);
          ACT_LOAD_B: append_id(list_b, len_b, item_i.value);
          ACT_RUN:    merge_lists();
          default:    ;
        endcase
      end
      pending_o <= merged_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

FILE: bench/testbench.sv
// Stimulus and verdict for the sorted list set merge unit. The checker beside
// the unit watches every accepted item and every result and does all of the
// predicting and comparing; this module drives the items, config writes and verdict.
module testbench;
  import slsm_pkg::*;

  localparam int unsigned LIST_DEPTH   = 32;
  localparam int unsigned ID_WIDTH     = 32;
  localparam int unsigned TARGET_ITEMS = 480;
  // Quiet cycles allowed before the run is declared hung. The slowest legal
  // stretch is a sender gap plus a full walk of both lists, well under this.
  localparam int unsigned QUIET_LIMIT  = 2000;
  // A load gives no result, so after the last result we still wait for the unit
  // to finish any load before touching the mode register.
  localparam int unsigned SETTLE_CYCLES = 8;

  // Codes the package does not name: the ignored action and the second
  // encoding of the difference mode.
  localparam logic [ACTION_W-1:0] ACT_IGNORED   = 2'd3;
  localparam logic [MODE_W-1:0]   MODE_DIFF_ALT = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          item_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [MODE_W-1:0] cfg_wdata_i = MODE_INTERSECT;
  logic              result_valid_o;
  out_item_t         result_o;

  int unsigned       pending;
  int unsigned       fail_count;

  // Bookkeeping for the sender and for the closing summary.
  int unsigned       burst_left = 0;
  int unsigned       items_sent = 0;
  int unsigned       runs_sent = 0;
  int unsigned       overflow_sets = 0;
  int unsigned       quiet_cycles = 0;

  // The two id lists of the set currently being loaded.
  logic [VALUE_W-1:0] a_ids [$];
  logic [VALUE_W-1:0] b_ids [$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_list_set_merge_unit #(
    .LIST_DEPTH(LIST_DEPTH),
    .ID_WIDTH  (ID_WIDTH)
  ) uut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .result_valid_o,
    .result_o
  );

  slsm_checker #(
    .LIST_DEPTH(LIST_DEPTH),
    .ID_WIDTH  (ID_WIDTH)
  ) merge_check (
    .clk_i,
    .rst_ni,
    .start_i       (start),
    .busy_i        (busy),
    .item_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .result_valid_i(result_valid_o),
    .result_i      (result_o),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Hang detection: any cycle that moves an item or a result restarts the
  // count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("sorted_list_set_merge_unit test failed");
        $finish;
      end
    end
  end

  // Offers one item and returns at the edge that accepts it. The sender works
  // in bursts: when a burst is used up it may drop start for a random gap
  // before the next one, and some bursts follow with no gap at all. Start is
  // only lowered when the gap is real, so it never sees two updates in one
  // step.
  task automatic send(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    start <= 1'b1;
    item_i <= '{action: act, value: val};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    burst_left--;
    if (act != ACT_IGNORED) begin
      items_sent++;
    end
    if (act == ACT_RUN) begin
      runs_sent++;
    end
  endtask

  // Holds the sender off until every predicted result has arrived and the
  // unit has gone quiet. This is the only place a config write may follow.
  task automatic settle();
    if (start) begin
      start <= 1'b0;
    end
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Builds two ascending lists from one shared walk over the id space, so
  // that ids land in A only, B only or in both and every mode has work to do.
  // The base sits near zero, near the top of the range or anywhere. If the
  // walk runs off the top it restarts low, which leaves an unsorted list.
  task automatic build_lists(input int unsigned want_a, input int unsigned want_b);
    logic [VALUE_W-1:0] cur;
    logic [VALUE_W-1:0] nxt;
    int unsigned        pick;
    a_ids.delete();
    b_ids.delete();
    case ($urandom_range(0, 3))
      0:       cur = $urandom_range(0, 15);
      1:       cur = 32'hFFFF_FFFF - $urandom_range(0, 511);
      default: cur = $urandom;
    endcase
    while (a_ids.size() < want_a || b_ids.size() < want_b) begin
      pick = $urandom_range(0, 2);
      if (a_ids.size() >= want_a) begin
        pick = 1;
      end else if (b_ids.size() >= want_b) begin
        pick = 0;
      end
      if (pick != 1) begin
        a_ids = {a_ids, cur};
      end
      if (pick != 0) begin
        b_ids = {b_ids, cur};
      end
      if ($urandom_range(0, 7) == 0) begin
        nxt = cur + $urandom_range(1, 1 << 20);
      end else begin
        nxt = cur + $urandom_range(1, 3);
      end
      if (nxt < cur) begin
        nxt = $urandom_range(0, 255);
      end
      cur = nxt;
    end
    // Now and then break the ordering on purpose by swapping two entries.
    if ($urandom_range(0, 9) == 0 && a_ids.size() > 1) begin
      pick = $urandom_range(1, a_ids.size() - 1);
      cur = a_ids[0];
      a_ids[0] = a_ids[pick];
      a_ids[pick] = cur;
    end
    if ($urandom_range(0, 9) == 0 && b_ids.size() > 1) begin
      pick = $urandom_range(1, b_ids.size() - 1);
      cur = b_ids[0];
      b_ids[0] = b_ids[pick];
      b_ids[pick] = cur;
    end
  endtask

  // Loads both lists with the A and B loads interleaved at random and a rare
  // ignored item mixed in, then usually runs the merge. A set without a run
  // leaves its ids to pile up under the next set.
  task automatic load_lists(input logic with_run);
    int unsigned ia;
    int unsigned ib;
    ia = 0;
    ib = 0;
    while (ia < a_ids.size() || ib < b_ids.size()) begin
      if ($urandom_range(0, 19) == 0) begin
        send(ACT_IGNORED, $urandom);
      end
      if (ib >= b_ids.size() || (ia < a_ids.size() && $urandom_range(0, 1) == 1)) begin
        send(ACT_LOAD_A, a_ids[ia]);
        ia++;
      end else begin
        send(ACT_LOAD_B, b_ids[ib]);
        ib++;
      end
    end
    if (with_run) begin
      send(ACT_RUN, $urandom);
    end
  endtask

  initial begin
    int unsigned       phase;
    int unsigned       want_a;
    int unsigned       want_b;
    logic              forced_full;
    logic [MODE_W-1:0] m;

    phase = 0;
    forced_full = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part. Out of reset the mode is intersection: a run on two
    // empty lists must give the lone empty result.
    send(ACT_RUN, 32'hDEAD_BEEF);
    // Intersection with ids at both ends of the range and an ignored item
    // mixed into the loads.
    send(ACT_LOAD_A, 32'h0000_0000);
    send(ACT_LOAD_A, 32'h0000_0005);
    send(ACT_LOAD_A, 32'hFFFF_FFFF);
    send(ACT_LOAD_B, 32'h0000_0005);
    send(ACT_IGNORED, 32'h1234_5678);
    send(ACT_LOAD_B, 32'hFFFF_FFFF);
    send(ACT_RUN, 32'h0000_0000);
    // Union: ids shared by both lists come out once.
    settle();
    write_mode(MODE_UNION);
    send(ACT_LOAD_A, 32'h0000_0001);
    send(ACT_LOAD_A, 32'h0000_0007);
    send(ACT_LOAD_B, 32'h0000_0000);
    send(ACT_LOAD_B, 32'h0000_0007);
    send(ACT_LOAD_B, 32'hFFFF_FFFF);
    send(ACT_RUN, 32'hFFFF_FFFF);
    // Difference with list A not sorted: the walk follows stored order.
    settle();
    write_mode(MODE_DIFF);
    send(ACT_LOAD_A, 32'h0000_0009);
    send(ACT_LOAD_A, 32'h0000_0003);
    send(ACT_LOAD_A, 32'h0000_0007);
    send(ACT_LOAD_B, 32'h0000_0003);
    send(ACT_LOAD_B, 32'h0000_0009);
    send(ACT_RUN, 32'h5555_AAAA);
    // Mode three also means difference; here the answer is empty.
    settle();
    write_mode(MODE_DIFF_ALT);
    send(ACT_LOAD_A, 32'h0000_0004);
    send(ACT_LOAD_B, 32'h0000_0004);
    send(ACT_RUN, 32'hAAAA_5555);

    // Random part. Each phase waits for the unit to drain, sets a mode and
    // loads several sets. The first four phases walk through every mode
    // encoding; later ones pick a mode at random. Most sets are short, a few
    // fill a list to its depth or past it so that loads get dropped.
    while (items_sent < TARGET_ITEMS) begin
      settle();
      case (phase)
        0:       m = MODE_INTERSECT;
        1:       m = MODE_UNION;
        2:       m = MODE_DIFF;
        3:       m = MODE_DIFF_ALT;
        default: m = MODE_W'($urandom_range(0, 3));
      endcase
      write_mode(m);
      repeat ($urandom_range(4, 8)) begin
        if (!forced_full) begin
          // One overfull list is guaranteed early on.
          want_a = LIST_DEPTH + 2;
          want_b = 3;
          forced_full = 1'b1;
        end else if ($urandom_range(0, 11) == 0) begin
          want_a = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 4);
          want_b = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 4);
        end else begin
          want_a = $urandom_range(0, 8);
          want_b = $urandom_range(0, 8);
        end
        if (want_a > LIST_DEPTH || want_b > LIST_DEPTH) begin
          overflow_sets++;
        end
        build_lists(want_a, want_b);
        load_lists($urandom_range(0, 15) != 0);
      end
      phase++;
    end

    // Drain, then leave room for anything stray a full walk could still emit.
    settle();
    repeat (2 * LIST_DEPTH + 8) @(posedge clk_i);

    $display("Sent %0d load and run items, %0d of them merge runs, over %0d mode phases.",
             items_sent, runs_sent, phase + 4);
    $display("%0d sets went past the list depth and had loads dropped.", overflow_sets);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_list_set_merge_unit test passed");
    end else begin
      $display("sorted_list_set_merge_unit test failed");
    end
    $finish;
  end

endmodule
